// ===== design/bly_pkg.sv =====
`timescale 1ns / 1ps

package bly_pkg;

   localparam int unsigned NODE_LIMIT = 16;
   localparam int unsigned ID_W       = 4;

   typedef enum logic [1:0] {
      MSG_ELECTIONS = 2'd0,
      MSG_ALIVE     = 2'd1,
      MSG_COORD     = 2'd2,
      MSG_TICK      = 2'd3
   } msg_kind_type;

   localparam logic [1:0] REG_NODE_ID       = 2'd0;
   localparam logic [1:0] REG_NEIGHBOR_MASK = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd12;

   typedef struct packed {
      logic [ID_W-1:0]       node_id;
      logic [NODE_LIMIT-1:0] neighbor_mask;
      logic [15:0]           timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      msg_kind_type          kind;
      logic [NODE_LIMIT-1:0] dest_mask;
      logic                  alive_en;
      logic [ID_W-1:0]       alive_dest;
      logic [ID_W-1:0]       leader;
   } job_type;

endpackage

// ===== design/bully_election_node.sv =====
`timescale 1ns / 1ps

// One node of a bully leader election. Each item on req_ is an event (elections, alive,
// coordinator message or time tick); each item on rsp_ is an outgoing message, in ascending
// destination order, with an alive reply after the elections group, and tlast on the final
// message of an event. An event that sends nothing leaves the block idle, and the next item
// can be taken in the following cycle. An event that sends messages runs the neighbour
// scanner, which steps one node position per cycle up to the highest destination, but holds
// at a destination while rsp_tready is low, then sends any alive reply; req_tready stays
// low meanwhile. Registers: node_id at 0x0, neighbor_mask at 0x4, timeout_ticks at 0x8.
module bully_election_node #(
   parameter int unsigned MAX_NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // sender[3:0], now_time[35:4], zero[39:36]
   input  logic [2:0]  req_tuser,   // event_kind[1:0], from_outside[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // destination[3:0], leader[7:4]
   output logic [1:0]  rsp_tuser,   // send_kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned SCAN = (MAX_NODES < bly_pkg::NODE_LIMIT) ? MAX_NODES
                                                                    : bly_pkg::NODE_LIMIT;
   localparam logic [bly_pkg::NODE_LIMIT-1:0] RANGE_MASK =
      bly_pkg::NODE_LIMIT'((33'd1 << SCAN) - 33'd1);

   bly_pkg::cfg_type              cfg;
   bly_pkg::job_type              job;
   logic                          scan_idle;

   logic                          in_election_ff, in_election_in;
   logic                          alive_seen_ff, alive_seen_in;
   logic                          stamp_valid_ff, stamp_valid_in;
   logic [31:0]                   stamp_ff, stamp_in;
   logic [bly_pkg::ID_W-1:0]      leader_ff, leader_in;

   logic                          accept;
   bly_pkg::msg_kind_type         ev_kind;
   logic [bly_pkg::ID_W-1:0]      sender;
   logic                          outside;
   logic [31:0]                   now_time;
   logic [bly_pkg::NODE_LIMIT-1:0] nbr;
   logic [bly_pkg::NODE_LIMIT-1:0] higher;
   logic [31:0]                   stamp_eff;
   logic                          expired;

   assign req_tready = scan_idle;
   assign accept     = req_tvalid && req_tready;
   assign ev_kind    = bly_pkg::msg_kind_type'(req_tuser[1:0]);
   assign outside    = req_tuser[2];
   assign sender     = req_tdata[3:0];
   assign now_time   = req_tdata[35:4];

   assign nbr       = cfg.neighbor_mask & RANGE_MASK;
   assign higher    = nbr & ~(bly_pkg::NODE_LIMIT'((33'd2 << cfg.node_id) - 33'd1));
   assign stamp_eff = stamp_valid_ff ? stamp_ff : now_time;
   // stamp plus timeout kept at 33 bits so it never wraps
   assign expired   = {1'b0, now_time} > ({1'b0, stamp_eff} + {17'd0, cfg.timeout_ticks});

   always_comb begin
      in_election_in = in_election_ff;
      alive_seen_in  = alive_seen_ff;
      stamp_valid_in = stamp_valid_ff;
      stamp_in       = stamp_ff;
      leader_in      = leader_ff;
      job.start      = accept;
      job.kind       = bly_pkg::MSG_ELECTIONS;
      job.dest_mask  = '0;
      job.alive_en   = 1'b0;
      job.alive_dest = sender;

      if (accept) begin
         case (ev_kind)
            bly_pkg::MSG_ELECTIONS: begin
               if (higher == '0) begin
                  job.kind       = bly_pkg::MSG_COORD;
                  job.dest_mask  = nbr;
                  in_election_in = 1'b0;
               end else begin
                  job.kind       = bly_pkg::MSG_ELECTIONS;
                  job.dest_mask  = higher;
                  job.alive_en   = !outside;
                  in_election_in = 1'b1;
               end
            end
            bly_pkg::MSG_ALIVE: begin
               alive_seen_in = 1'b1;
            end
            bly_pkg::MSG_COORD: begin
               if (outside || sender < cfg.node_id) begin
                  job.kind      = bly_pkg::MSG_COORD;
                  job.dest_mask = nbr;
                  leader_in     = cfg.node_id;
               end else begin
                  leader_in = sender;
               end
               alive_seen_in  = 1'b0;
               stamp_valid_in = 1'b0;
               in_election_in = 1'b0;
            end
            bly_pkg::MSG_TICK: begin
               if (in_election_ff) begin
                  if (!stamp_valid_ff) begin
                     stamp_in       = now_time;
                     stamp_valid_in = 1'b1;
                  end
                  if (expired) begin
                     if (!alive_seen_ff) begin
                        job.kind       = bly_pkg::MSG_COORD;
                        job.dest_mask  = nbr;
                        leader_in      = cfg.node_id;
                        in_election_in = 1'b0;
                     end else begin
                        job.kind      = bly_pkg::MSG_ELECTIONS;
                        job.dest_mask = higher;
                     end
                     stamp_valid_in = 1'b0;
                  end
               end
            end
            default: job.start = accept;
         endcase
      end
      job.leader = leader_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_election_ff <= 1'b0;
         alive_seen_ff  <= 1'b0;
         stamp_valid_ff <= 1'b0;
         stamp_ff       <= '0;
         leader_ff      <= '0;
      end else begin
         in_election_ff <= in_election_in;
         alive_seen_ff  <= alive_seen_in;
         stamp_valid_ff <= stamp_valid_in;
         stamp_ff       <= stamp_in;
         leader_ff      <= leader_in;
      end
   end

   bly_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bly_scan #(
      .NODES (SCAN)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .idle       (scan_idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // the stamp is only armed while an election runs
   a_stamp_needs_election: assert property (@(posedge clock) disable iff (reset)
      $rose(stamp_valid_ff) |-> $past(in_election_ff))
      else $error("stamp armed outside an election");

   // an accepted coordinator item clears the election
   a_coord_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && ev_kind == bly_pkg::MSG_COORD) |=> !in_election_ff && !alive_seen_ff)
      else $error("coordinator did not end the election");

   // a stalled outgoing item stays put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         rsp_tvalid && $stable({rsp_tdata, rsp_tuser, rsp_tlast}))
      else $error("outgoing item changed while stalled");

endmodule

// ===== design/bly_csr.sv =====
`timescale 1ns / 1ps

module bly_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output bly_pkg::cfg_type cfg
);

   bly_pkg::cfg_type cfg_ff;
   bly_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            bly_pkg::REG_NODE_ID:       cfg_in.node_id = csr_pwdata[bly_pkg::ID_W-1:0];
            bly_pkg::REG_NEIGHBOR_MASK: cfg_in.neighbor_mask =
                                           csr_pwdata[bly_pkg::NODE_LIMIT-1:0];
            bly_pkg::REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_pwdata[15:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         bly_pkg::REG_NODE_ID:       csr_prdata = {28'd0, cfg_ff.node_id};
         bly_pkg::REG_NEIGHBOR_MASK: csr_prdata = {16'd0, cfg_ff.neighbor_mask};
         bly_pkg::REG_TIMEOUT_TICKS: csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id       <= '0;
         cfg_ff.neighbor_mask <= '0;
         cfg_ff.timeout_ticks <= bly_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/bly_scan.sv =====
`timescale 1ns / 1ps

module bly_scan #(
   parameter int unsigned NODES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  bly_pkg::job_type job,
   output logic             idle,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_ALIVE
   } state_type;

   state_type                      state_ff, state_in;
   logic [NODES-1:0]               mask_ff, mask_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   bly_pkg::msg_kind_type          kind_ff, kind_in;
   logic                           alive_ff, alive_in;
   logic [bly_pkg::ID_W-1:0]       alive_dest_ff, alive_dest_in;
   logic [bly_pkg::ID_W-1:0]       leader_ff, leader_in;

   logic                           out_valid_ff, out_valid_in;
   bly_pkg::msg_kind_type          out_kind_ff, out_kind_in;
   logic [bly_pkg::ID_W-1:0]       out_dest_ff, out_dest_in;
   logic [bly_pkg::ID_W-1:0]       out_leader_ff, out_leader_in;
   logic                           out_last_ff, out_last_in;

   logic                           can_load;
   logic [NODES-1:0]               rest;
   logic [NODES-1:0]               job_mask;

   assign can_load = !out_valid_ff || rsp_tready;
   assign rest     = mask_ff & ~({{(NODES-1){1'b0}}, 1'b1} << idx_ff);
   assign job_mask = job.dest_mask[NODES-1:0];
   assign idle     = (state_ff == S_IDLE);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_leader_ff, out_dest_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      alive_in      = alive_ff;
      alive_dest_in = alive_dest_ff;
      leader_in     = leader_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_dest_in   = out_dest_ff;
      out_leader_in = out_leader_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (job.start) begin
               mask_in       = job_mask;
               idx_in        = '0;
               kind_in       = job.kind;
               alive_in      = job.alive_en;
               alive_dest_in = job.alive_dest;
               leader_in     = job.leader;
               if (job_mask != '0) begin
                  state_in = S_SCAN;
               end else if (job.alive_en) begin
                  state_in = S_ALIVE;
               end
            end
         end
         S_SCAN: begin
            if (mask_ff[idx_ff]) begin
               if (can_load) begin
                  out_valid_in  = 1'b1;
                  out_kind_in   = kind_ff;
                  out_dest_in   = bly_pkg::ID_W'(idx_ff);
                  out_leader_in = leader_ff;
                  out_last_in   = (rest == '0) && !alive_ff;
                  mask_in       = rest;
                  if (rest == '0) begin
                     state_in = alive_ff ? S_ALIVE : S_IDLE;
                  end else begin
                     idx_in = IDX_W'(idx_ff + 1'b1);
                  end
               end
            end else begin
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end
         S_ALIVE: begin
            if (can_load) begin
               out_valid_in  = 1'b1;
               out_kind_in   = bly_pkg::MSG_ALIVE;
               out_dest_in   = alive_dest_ff;
               out_leader_in = leader_ff;
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mask_ff       <= mask_in;
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      alive_ff      <= alive_in;
      alive_dest_ff <= alive_dest_in;
      leader_ff     <= leader_in;
      out_kind_ff   <= out_kind_in;
      out_dest_ff   <= out_dest_in;
      out_leader_ff <= out_leader_in;
      out_last_ff   <= out_last_in;
   end

   // a new job may only arrive while no scan is running
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      job.start |-> state_ff == S_IDLE)
      else $error("job started while scan busy");

   // loading the final item of a run ends the scan
   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (can_load && out_valid_in && out_last_in && state_ff != S_IDLE)
         |=> state_ff == S_IDLE)
      else $error("scan still running after last item");

   // the alive reply always closes its run
   a_alive_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == bly_pkg::MSG_ALIVE) |-> rsp_tlast)
      else $error("alive reply not marked last");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int QUIET_LIMIT = 1000;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASES = 4;
   localparam int ITEMS_PER_PHASE = 19;

   typedef enum logic [1:0] {
      ROW_CFG,
      ROW_EVENT_PRED,
      ROW_EVENT_NONE,
      ROW_EVENT_ONE
   } row_how_type;

   typedef struct packed {
      row_how_type           how;
      logic [1:0]            csr_reg;
      bly_pkg::msg_kind_type kind;
      logic [3:0]            sender;
      logic                  outside;
      logic [31:0]           word;      // now_time for events, register value for writes
      bly_pkg::msg_kind_type t_kind;
      logic [3:0]            t_dest;
      logic [3:0]            t_leader;
   } stim_row_type;

   typedef struct packed {
      bly_pkg::msg_kind_type kind;
      logic [3:0]            dest;
      logic [3:0]            leader;
      logic                  last;
   } outbound_msg_type;

   localparam int DIRECTED_ROWS = 32;
   localparam stim_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // reset settings: node 0 with no neighbours
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_ELECTIONS, 4'd15, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_COORD, 4'd15, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_ALIVE, 4'd0, 1'b1, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      // node 5, neighbours 0, 5 (self) and 15, longest timeout
      '{ROW_CFG, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd5,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_CFG, bly_pkg::REG_NEIGHBOR_MASK, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'h8021,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_CFG, bly_pkg::REG_TIMEOUT_TICKS, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'hFFFF,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_PRED, bly_pkg::REG_NODE_ID, bly_pkg::MSG_ELECTIONS, 4'd0, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      // stamp near the top of the range, the sum must not wrap
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'hFFFF_FFF0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd15, 1'b1, 32'hFFFF_FFFF,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_COORD, 4'd15, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_ALIVE, 4'd9, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      // external elections: no alive reply
      '{ROW_EVENT_ONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_ELECTIONS, 4'd3, 1'b1, 32'd0,
        bly_pkg::MSG_ELECTIONS, 4'd15, 4'd15},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'h0000_FFFF,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      // timeout with alive seen restarts the election
      '{ROW_EVENT_ONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'h0001_0000,
        bly_pkg::MSG_ELECTIONS, 4'd15, 4'd15},
      '{ROW_EVENT_PRED, bly_pkg::REG_NODE_ID, bly_pkg::MSG_COORD, 4'd15, 1'b1, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_CFG, bly_pkg::REG_TIMEOUT_TICKS, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_PRED, bly_pkg::REG_NODE_ID, bly_pkg::MSG_ELECTIONS, 4'd2, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd100,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_PRED, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd101,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_PRED, bly_pkg::REG_NODE_ID, bly_pkg::MSG_COORD, 4'd3, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_COORD, 4'd5, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      // top node with every neighbour
      '{ROW_CFG, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd15,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_CFG, bly_pkg::REG_NEIGHBOR_MASK, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'hFFFF,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_PRED, bly_pkg::REG_NODE_ID, bly_pkg::MSG_ELECTIONS, 4'd7, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_PRED, bly_pkg::REG_NODE_ID, bly_pkg::MSG_COORD, 4'd0, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      // bottom node with every neighbour
      '{ROW_CFG, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_CFG, bly_pkg::REG_TIMEOUT_TICKS, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'd12,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_PRED, bly_pkg::REG_NODE_ID, bly_pkg::MSG_ELECTIONS, 4'd9, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_COORD, 4'd0, 1'b0, 32'd0,
        bly_pkg::MSG_TICK, 4'd0, 4'd0},
      '{ROW_EVENT_NONE, bly_pkg::REG_NODE_ID, bly_pkg::MSG_TICK, 4'd0, 1'b0, 32'h5A5A_5A5A,
        bly_pkg::MSG_TICK, 4'd0, 4'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;    // sender[3:0], now_time[35:4], zero[39:36]
   logic [2:0]  req_tuser = '0;    // event_kind[1:0], from_outside[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // destination[3:0], leader[7:4]
   logic [1:0]  rsp_tuser;         // send_kind[1:0]
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor copy of the registers and the election state
   logic [3:0]  cfg_node = '0;
   logic [15:0] cfg_mask = '0;
   logic [15:0] cfg_timeout = bly_pkg::TIMEOUT_RESET;
   logic        electing = 1'b0;
   logic        alive_heard = 1'b0;
   logic        stamp_set = 1'b0;
   logic [31:0] stamp_time = '0;
   logic [3:0]  leader_now = '0;

   outbound_msg_type step_msgs[$];
   outbound_msg_type awaited_msgs[$];
   stim_row_type     item_notes[$];

   int          errors = 0;
   int          quiet_cycles = 0;
   int          burst_left = 0;
   logic        gapless = 1'b0;
   logic [7:0]  stall_bits = 8'hFF;
   int          stall_age = 0;
   stim_row_type     note;
   outbound_msg_type want;

   bully_election_node i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      if (errors < 40) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
      errors++;
   endtask

   function automatic void add_group(input bly_pkg::msg_kind_type k, input logic only_higher);
      for (int i = 0; i < bly_pkg::NODE_LIMIT; i++) begin
         if (cfg_mask[i] && (!only_higher || i > int'(cfg_node))) begin
            step_msgs.push_back('{kind: k, dest: 4'(i), leader: 4'd0, last: 1'b0});
         end
      end
   endfunction

   function automatic void run_election_step(input bly_pkg::msg_kind_type k,
                                             input logic [3:0] from_id,
                                             input logic outside, input logic [31:0] now);
      step_msgs.delete();
      case (k)
         bly_pkg::MSG_ELECTIONS: begin
            electing = 1'b1;
            if ((cfg_mask >> (int'(cfg_node) + 1)) == '0) begin
               add_group(bly_pkg::MSG_COORD, 1'b0);
               electing = 1'b0;
            end else begin
               add_group(bly_pkg::MSG_ELECTIONS, 1'b1);
               if (!outside) begin
                  step_msgs.push_back('{kind: bly_pkg::MSG_ALIVE, dest: from_id,
                                        leader: 4'd0, last: 1'b0});
               end
            end
         end
         bly_pkg::MSG_ALIVE: begin
            alive_heard = 1'b1;
         end
         bly_pkg::MSG_COORD: begin
            if (outside || from_id < cfg_node) begin
               add_group(bly_pkg::MSG_COORD, 1'b0);
               leader_now = cfg_node;
            end else begin
               leader_now = from_id;
            end
            alive_heard = 1'b0;
            stamp_set = 1'b0;
            electing = 1'b0;
         end
         bly_pkg::MSG_TICK: begin
            if (electing) begin
               if (!stamp_set) begin
                  stamp_time = now;
                  stamp_set = 1'b1;
               end
               // 33-bit compare so the deadline never wraps
               if ({1'b0, now} > {1'b0, stamp_time} + {17'b0, cfg_timeout}) begin
                  if (!alive_heard) begin
                     add_group(bly_pkg::MSG_COORD, 1'b0);
                     leader_now = cfg_node;
                     electing = 1'b0;
                  end else begin
                     add_group(bly_pkg::MSG_ELECTIONS, 1'b1);
                  end
                  stamp_set = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      foreach (step_msgs[j]) begin
         step_msgs[j].leader = leader_now;
      end
      if (step_msgs.size() > 0) begin
         step_msgs[step_msgs.size() - 1].last = 1'b1;
      end
   endfunction

   // checker, predictor hookup and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            note = item_notes.pop_front();
            run_election_step(bly_pkg::msg_kind_type'(req_tuser[1:0]), req_tdata[3:0],
                              req_tuser[2], req_tdata[35:4]);
            case (note.how)
               ROW_EVENT_ONE: begin
                  awaited_msgs.push_back('{kind: note.t_kind, dest: note.t_dest,
                                           leader: note.t_leader, last: 1'b1});
               end
               ROW_EVENT_NONE: begin
               end
               default: begin
                  foreach (step_msgs[j]) begin
                     awaited_msgs.push_back(step_msgs[j]);
                  end
               end
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_msgs.size() == 0) begin
               flag_error($sformatf("unexpected item: kind %0d dest %0d leader %0d last %0b",
                                    rsp_tuser, rsp_tdata[3:0], rsp_tdata[7:4], rsp_tlast));
            end else begin
               want = awaited_msgs.pop_front();
               if (rsp_tuser !== want.kind) begin
                  flag_error($sformatf("send_kind %0d, wanted %0d", rsp_tuser, want.kind));
               end
               if (rsp_tdata[3:0] !== want.dest) begin
                  flag_error($sformatf("destination %0d, wanted %0d", rsp_tdata[3:0],
                                       want.dest));
               end
               if (rsp_tdata[7:4] !== want.leader) begin
                  flag_error($sformatf("leader %0d, wanted %0d", rsp_tdata[7:4], want.leader));
               end
               if (rsp_tlast !== want.last) begin
                  flag_error($sformatf("last_of_run %0b, wanted %0b", rsp_tlast, want.last));
               end
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("bully_election_node: mismatch");
         $finish;
      end
   end

   // receiver backpressure: a rotating pattern, replaced now and then
   always @(negedge clock) begin
      if (stall_age == 0) begin
         stall_bits = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         stall_age = $urandom_range(16, 80);
      end else begin
         stall_age--;
      end
      stall_bits = {stall_bits[0], stall_bits[7:1]};
      rsp_tready <= stall_bits[0];
   end

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         bly_pkg::REG_NODE_ID:       cfg_node = value[3:0];
         bly_pkg::REG_NEIGHBOR_MASK: cfg_mask = value[15:0];
         bly_pkg::REG_TIMEOUT_TICKS: cfg_timeout = value[15:0];
         default: begin
         end
      endcase
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_msgs.size() != 0 || item_notes.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // drained, then long enough for a silent event to finish inside the block
   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_event(input stim_row_type row);
      @(negedge clock);
      req_tdata <= {4'b0, row.word, row.sender};
      req_tuser <= {row.outside, row.kind};
      req_tvalid <= 1'b1;
      item_notes.push_back(row);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         if (!gapless) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   initial begin
      stim_row_type row;
      logic [31:0]  tick_now;
      int           pick;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (DIRECTED[r].how == ROW_CFG) begin
            settle();
            csr_write(DIRECTED[r].csr_reg, DIRECTED[r].word);
         end else begin
            send_event(DIRECTED[r]);
            pace_sender();
         end
      end

      tick_now = $urandom;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         gapless = (phase == 1);
         csr_write(bly_pkg::REG_NODE_ID, 32'($urandom_range(0, 15)));
         case (phase)
            0: begin
               csr_write(bly_pkg::REG_NEIGHBOR_MASK, 32'($urandom_range(0, 16'hFFFF)));
               csr_write(bly_pkg::REG_TIMEOUT_TICKS, 32'($urandom_range(0, 8)));
            end
            1: begin
               csr_write(bly_pkg::REG_NEIGHBOR_MASK, 32'hFFFF);
               csr_write(bly_pkg::REG_TIMEOUT_TICKS, 32'd0);
            end
            2: begin
               csr_write(bly_pkg::REG_NEIGHBOR_MASK, 32'($urandom_range(0, 16'hFFFF)));
               csr_write(bly_pkg::REG_TIMEOUT_TICKS, 32'hFFFF);
            end
            default: begin
               csr_write(bly_pkg::REG_NEIGHBOR_MASK, 32'($urandom & $urandom & 32'hFFFF));
               csr_write(bly_pkg::REG_TIMEOUT_TICKS, 32'($urandom_range(1, 20)));
            end
         endcase

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            row = '0;
            row.how = ROW_EVENT_PRED;
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               row.kind = bly_pkg::MSG_ELECTIONS;
            end else if (pick < 32) begin
               row.kind = bly_pkg::MSG_ALIVE;
            end else if (pick < 50) begin
               row.kind = bly_pkg::MSG_COORD;
            end else begin
               row.kind = bly_pkg::MSG_TICK;
            end
            row.sender = 4'($urandom_range(0, 15));
            row.outside = ($urandom_range(0, 3) == 0);
            // mostly small steps forward, sometimes large ones, rarely a jump anywhere
            if ($urandom_range(0, 24) == 0) begin
               tick_now = $urandom;
            end else if ($urandom_range(0, 9) == 0) begin
               tick_now = tick_now + 32'($urandom_range(0, 20'hFFFFF));
            end else begin
               tick_now = tick_now + 32'($urandom_range(0, 4));
            end
            row.word = (row.kind == bly_pkg::MSG_TICK) ? tick_now : $urandom;
            send_event(row);
            if ($urandom_range(0, 29) == 0) begin
               hold_until_drained();
            end else begin
               pace_sender();
            end
         end
      end

      settle();
      if (errors == 0) begin
         $display("bully_election_node: match");
      end else begin
         $display("bully_election_node: mismatch");
      end
      $finish;
   end

endmodule
